// ===== src/c_st_pkg.sv =====
// Shared types and constants for the C-subset tokenizer.
// Lexer modes, token kinds, reserved codes, character codes, keyword table.
// No dependencies.
`default_nettype none

package c_st_pkg;

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_LT     = 3'd1,
        M_GT     = 3'd2,
        M_EQ     = 3'd3,
        M_BANG   = 3'd4,
        M_WORD   = 3'd5,
        M_NUMBER = 3'd6,
        M_DROP   = 3'd7
    } mode_t;

    // push request from the lexer into the result queue
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    localparam logic [2:0] K_RES   = 3'd0;
    localparam logic [2:0] K_NUM   = 3'd1;
    localparam logic [2:0] K_IDENT = 3'd2;
    localparam logic [2:0] K_EOF   = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    localparam logic [4:0] RC_LE     = 5'd0;
    localparam logic [4:0] RC_GE     = 5'd1;
    localparam logic [4:0] RC_PLUS   = 5'd2;
    localparam logic [4:0] RC_MINUS  = 5'd3;
    localparam logic [4:0] RC_STAR   = 5'd4;
    localparam logic [4:0] RC_SLASH  = 5'd5;
    localparam logic [4:0] RC_LPAREN = 5'd6;
    localparam logic [4:0] RC_RPAREN = 5'd7;
    localparam logic [4:0] RC_LBRACE = 5'd8;
    localparam logic [4:0] RC_RBRACE = 5'd9;
    localparam logic [4:0] RC_LT     = 5'd10;
    localparam logic [4:0] RC_GT     = 5'd11;
    localparam logic [4:0] RC_SEMI   = 5'd12;
    localparam logic [4:0] RC_COMMA  = 5'd13;
    localparam logic [4:0] RC_AMP    = 5'd14;
    localparam logic [4:0] RC_INT    = 5'd15;
    localparam logic [4:0] RC_EQEQ   = 5'd21;
    localparam logic [4:0] RC_NE     = 5'd22;
    localparam logic [4:0] RC_ASSIGN = 5'd23;
    localparam logic [4:0] RC_NONE   = 5'd0;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int NUM_KW = 6;

    // keyword letters right-aligned, same packing as the word shift register
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'h0000_0069_6E74,   // int
        48'h0000_0000_6966,   // if
        48'h0000_0066_6F72,   // for
        48'h0000_656C_7365,   // else
        48'h7265_7475_726E,   // return
        48'h0077_6869_6C65    // while
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd2, 3'd3, 3'd4, 3'd6, 3'd5};

endpackage

`default_nettype wire

// ===== src/c_st_fifo.sv =====
// Four-entry result queue; takes up to two tokens per cycle, gives one.
// Depends on c_st_pkg (push_t).
`default_nettype none

module c_st_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire c_st_pkg::push_t   push,
    input  wire logic [WIDTH-1:0]  din0,
    input  wire logic [WIDTH-1:0]  din1,
    output logic                   room,
    input  wire logic              pop,
    output logic [WIDTH-1:0]       dout,
    output logic                   dout_valid
);
    import c_st_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [PW:0]      count_reg, count_next;
    logic [PW:0]      n_in;
    logic             pop_ok;

    assign pop_ok     = pop && (count_reg != '0);
    assign n_in       = (PW+1)'(push.first) + (PW+1)'(push.second);
    assign wr_next    = wr_reg + PW'(n_in);
    assign rd_next    = rd_reg + PW'(pop_ok);
    assign count_next = count_reg + n_in - (PW+1)'(pop_ok);

    // the lexer only fires with two free slots
    assign room       = count_reg <= (PW+1)'(DEPTH - 2);
    assign dout       = mem_reg[rd_reg];
    assign dout_valid = count_reg != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_reg] <= din0;
        end
        if (push.second)
        begin
            mem_reg[wr_reg + PW'(1)] <= din1;
        end
    end

endmodule

`default_nettype wire

// ===== src/c_st_lex.sv =====
// Lexer core: input register, lexer state and per-byte token logic.
// Produces up to two tokens per byte. Depends on c_st_pkg.
`default_nettype none

module c_st_lex #(
    parameter int POSITION_BITS = 16,
    parameter int VALUE_BITS    = 31,
    localparam int TOK_W        = 3 + 5 + 2 * POSITION_BITS + VALUE_BITS + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        ch,
    input  wire logic              end_of_text,
    input  wire logic              room,
    output c_st_pkg::push_t        push,
    output logic [TOK_W-1:0]       tok0,
    output logic [TOK_W-1:0]       tok1
);
    import c_st_pkg::*;

    localparam int P = POSITION_BITS;
    localparam int V = VALUE_BITS;

    typedef struct packed {
        logic [2:0]   kind;
        logic [4:0]   code;
        logic [P-1:0] start;
        logic [P-1:0] len;
        logic [V-1:0] value;
        logic         last;
    } tok_t;

    logic         in_valid_reg;
    logic [7:0]   ch_reg;
    logic         eot_reg;
    logic         fire;

    mode_t        mode_reg, mode_next;
    logic [47:0]  word_reg, word_next;
    logic [P-1:0] start_reg, start_next;
    logic [P-1:0] len_reg, len_next;
    logic [V-1:0] acc_reg, acc_next;
    logic [P-1:0] pos_reg, pos_next;

    logic         c_ws, c_lower, c_letter, c_digit, c_wordch;
    logic         c_single;
    logic [4:0]   single_code;
    mode_t        idle_mode;
    tok_t         s_tok, f_tok, a_tok, b_tok, pair_tok, eof_tok;
    logic         s_v, f_v, a_v, b_v;
    logic         kw_hit;
    logic [4:0]   kw_code;
    logic [4:0]   pair_code;
    logic [3:0]   digit;
    logic [V+3:0] acc_x10;
    logic [P-1:0] len_inc;
    logic         restart;

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= ch;
            eot_reg <= end_of_text;
        end
    end

    // character classes
    assign c_ws     = (ch_reg == CH_SPACE) || (ch_reg >= CH_TAB && ch_reg <= CH_CR);
    assign c_lower  = ch_reg >= CH_LA && ch_reg <= CH_LZ;
    assign c_letter = c_lower || (ch_reg >= CH_UA && ch_reg <= CH_UZ);
    assign c_digit  = ch_reg >= CH_ZERO && ch_reg <= CH_NINE;
    assign c_wordch = c_letter || c_digit || (ch_reg == CH_UNDER);
    assign digit    = ch_reg[3:0];

    always_comb
    begin
        c_single    = 1'b1;
        single_code = RC_NONE;
        case (ch_reg)
            CH_PLUS:   single_code = RC_PLUS;
            CH_MINUS:  single_code = RC_MINUS;
            CH_STAR:   single_code = RC_STAR;
            CH_SLASH:  single_code = RC_SLASH;
            CH_LPAREN: single_code = RC_LPAREN;
            CH_RPAREN: single_code = RC_RPAREN;
            CH_LBRACE: single_code = RC_LBRACE;
            CH_RBRACE: single_code = RC_RBRACE;
            CH_SEMI:   single_code = RC_SEMI;
            CH_COMMA:  single_code = RC_COMMA;
            CH_AMP:    single_code = RC_AMP;
            default:   c_single    = 1'b0;
        endcase
    end

    // mode entered when a byte starts a new token
    always_comb
    begin
        if (c_ws || c_single)         idle_mode = M_IDLE;
        else if (ch_reg == CH_LT)     idle_mode = M_LT;
        else if (ch_reg == CH_GT)     idle_mode = M_GT;
        else if (ch_reg == CH_EQ)     idle_mode = M_EQ;
        else if (ch_reg == CH_BANG)   idle_mode = M_BANG;
        else if (c_lower)             idle_mode = M_WORD;
        else if (c_digit)             idle_mode = M_NUMBER;
        else                          idle_mode = M_DROP;
    end

    // token emitted directly by a starting byte: single punctuator or bad byte
    always_comb
    begin
        s_tok       = '0;
        s_tok.start = pos_reg;
        s_tok.len   = P'(1);
        s_v         = 1'b0;
        if (c_single)
        begin
            s_tok.kind = K_RES;
            s_tok.code = single_code;
            s_v        = 1'b1;
        end
        else if (idle_mode == M_DROP)
        begin
            s_tok.kind = K_ERR;
            s_v        = 1'b1;
        end
    end

    always_comb
    begin
        kw_hit  = 1'b0;
        kw_code = RC_INT;
        for (int i = 0; i < NUM_KW; i++)
        begin
            if (len_reg == P'(KW_LEN[i]) && word_reg == KW_TEXT[i])
            begin
                kw_hit  = 1'b1;
                kw_code = RC_INT + 5'(i);
            end
        end
    end

    // pending token, closed by the current byte or by the end marker
    always_comb
    begin
        f_tok       = '0;
        f_tok.start = start_reg;
        f_tok.len   = P'(1);
        f_v         = 1'b1;
        case (mode_reg)
            M_LT:
            begin
                f_tok.kind = K_RES;
                f_tok.code = RC_LT;
            end
            M_GT:
            begin
                f_tok.kind = K_RES;
                f_tok.code = RC_GT;
            end
            M_EQ:
            begin
                f_tok.kind = K_RES;
                f_tok.code = RC_ASSIGN;
            end
            M_BANG:
            begin
                f_tok.kind = K_ERR;
            end
            M_WORD:
            begin
                f_tok.len = len_reg;
                if (kw_hit && (eot_reg || !c_wordch))
                begin
                    f_tok.kind = K_RES;
                    f_tok.code = kw_code;
                end
                else
                begin
                    f_tok.kind = K_IDENT;
                end
            end
            M_NUMBER:
            begin
                f_tok.kind  = K_NUM;
                f_tok.len   = len_reg;
                f_tok.value = acc_reg;
            end
            default:
            begin
                f_v = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            M_LT:    pair_code = RC_LE;
            M_GT:    pair_code = RC_GE;
            M_EQ:    pair_code = RC_EQEQ;
            default: pair_code = RC_NE;
        endcase
        pair_tok       = '0;
        pair_tok.kind  = K_RES;
        pair_tok.code  = pair_code;
        pair_tok.start = start_reg;
        pair_tok.len   = P'(2);
        eof_tok        = '0;
        eof_tok.kind   = K_EOF;
        eof_tok.start  = pos_reg;
    end

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (eot_reg)
        begin
            mode_next = M_IDLE;
        end
        else
        begin
            case (mode_reg)
                M_DROP:   mode_next = M_DROP;
                M_LT, M_GT, M_EQ, M_BANG:
                begin
                    if (ch_reg == CH_EQ)          mode_next = M_IDLE;
                    else if (mode_reg == M_BANG)  mode_next = M_DROP;
                    else                          mode_next = idle_mode;
                end
                M_WORD:   mode_next = c_letter ? M_WORD : idle_mode;
                M_NUMBER: mode_next = c_digit ? M_NUMBER : idle_mode;
                default:  mode_next = idle_mode;
            endcase
        end
    end

    // token outputs: a then b, either may be absent
    always_comb
    begin
        a_tok = f_tok;
        a_v   = 1'b0;
        b_tok = s_tok;
        b_v   = 1'b0;
        if (eot_reg)
        begin
            a_v   = f_v;
            b_tok = eof_tok;
            b_v   = 1'b1;
        end
        else
        begin
            case (mode_reg)
                M_DROP:
                begin
                    a_v = 1'b0;
                end
                M_LT, M_GT, M_EQ, M_BANG:
                begin
                    if (ch_reg == CH_EQ)
                    begin
                        a_tok = pair_tok;
                        a_v   = 1'b1;
                    end
                    else if (mode_reg == M_BANG)
                    begin
                        a_v = 1'b1;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        b_v = s_v;
                    end
                end
                M_WORD:
                begin
                    a_v = !c_letter;
                    b_v = !c_letter && s_v;
                end
                M_NUMBER:
                begin
                    a_v = !c_digit;
                    b_v = !c_digit && s_v;
                end
                default:
                begin
                    b_v = s_v;
                end
            endcase
        end
    end

    always_comb
    begin
        tok_t t0;
        tok_t t1;
        t0          = a_v ? a_tok : b_tok;
        t0.last     = !(a_v && b_v);
        t1          = b_tok;
        t1.last     = 1'b1;
        tok0        = t0;
        tok1        = t1;
        push.first  = fire && (a_v || b_v);
        push.second = fire && a_v && b_v;
    end

    // datapath next values
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + (V+4)'(digit);
    assign len_inc = (len_reg != '1) ? len_reg + P'(1) : len_reg;
    assign restart = (mode_reg == M_IDLE)
                  || ((mode_reg == M_LT || mode_reg == M_GT || mode_reg == M_EQ)
                      && ch_reg != CH_EQ)
                  || (mode_reg == M_WORD && !c_letter)
                  || (mode_reg == M_NUMBER && !c_digit);

    always_comb
    begin
        word_next  = word_reg;
        start_next = start_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg + P'(1);
        if (eot_reg)
        begin
            word_next  = '0;
            start_next = '0;
            len_next   = '0;
            acc_next   = '0;
            pos_next   = '0;
        end
        else if (restart)
        begin
            start_next = pos_reg;
            len_next   = P'(1);
            if (c_lower)
            begin
                word_next = {40'b0, ch_reg};
            end
            if (c_digit)
            begin
                acc_next = V'(digit);
            end
        end
        else if (mode_reg == M_WORD)
        begin
            word_next = {word_reg[39:0], ch_reg};
            len_next  = len_inc;
        end
        else if (mode_reg == M_NUMBER)
        begin
            // saturate when 10*acc + d overflows the value width
            acc_next = (acc_x10[V+3:V] != '0) ? '1 : acc_x10[V-1:0];
            len_next = len_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            word_reg  <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            word_reg  <= word_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/c_subset_tokenizer.sv =====
// Streaming tokenizer for a small C subset.
// Source bytes come in on the in_* channel (ch, end_of_text); tokens leave
// on the out_* channel as kind, reserved_code, start_position, length,
// number_value and last. last marks the final token caused by one byte.
// A byte is held in the input register, then the lexer updates its
// state and pushes zero, one or two tokens into a four-entry result queue.
// A token shows on out_valid once the byte that ends it has passed the
// input register and the lexer has pushed the token into the queue.
// One byte is taken per cycle while the queue has two free slots; a byte
// that yields two tokens leaves the queue one token at a time, so the output
// side sets the rate when most bytes close two tokens.
// When the receiver stalls, the queue fills; once fewer than two slots are
// free a byte waits in the input register and in_ready drops, so nothing
// is lost. The end marker flushes the pending token, emits end of file and
// restarts offsets at zero.
// Reset (rst_n low) empties the queue and returns the lexer to idle at
// offset zero. Depends on c_st_pkg, c_st_lex and c_st_fifo.
`default_nettype none

module c_subset_tokenizer #(
    parameter int POSITION_BITS = 16,
    parameter int VALUE_BITS    = 31
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                ch,
    input  wire logic                      end_of_text,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [2:0]                     kind,
    output logic [4:0]                     reserved_code,
    output logic [POSITION_BITS-1:0]       start_position,
    output logic [POSITION_BITS-1:0]       length,
    output logic [VALUE_BITS-1:0]          number_value,
    output logic                           last
);
    import c_st_pkg::*;

    localparam int P     = POSITION_BITS;
    localparam int V     = VALUE_BITS;
    localparam int TOK_W = 3 + 5 + 2 * P + V + 1;

    typedef struct packed {
        logic [2:0]   kind;
        logic [4:0]   code;
        logic [P-1:0] start;
        logic [P-1:0] len;
        logic [V-1:0] value;
        logic         last;
    } tok_t;

    push_t            push;
    logic             room;
    logic [TOK_W-1:0] tok0, tok1, head_bits;
    tok_t             head;

    c_st_lex #(
        .POSITION_BITS (P),
        .VALUE_BITS    (V)
    ) u_lex (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .end_of_text (end_of_text),
        .room        (room),
        .push        (push),
        .tok0        (tok0),
        .tok1        (tok1)
    );

    c_st_fifo #(
        .WIDTH (TOK_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .din0       (tok0),
        .din1       (tok1),
        .room       (room),
        .pop        (out_ready),
        .dout       (head_bits),
        .dout_valid (out_valid)
    );

    assign head           = head_bits;
    assign kind           = head.kind;
    assign reserved_code  = head.code;
    assign start_position = head.start;
    assign length         = head.len;
    assign number_value   = head.value;
    assign last           = head.last;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> room)
        else $error("token pushed into a full result queue");

    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second token pushed without a first");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == K_EOF) |-> (last && length == '0))
        else $error("end-of-file token not last or has nonzero length");

    a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != K_RES && kind != K_NUM)
            |-> (reserved_code == RC_NONE && number_value == '0))
        else $error("code or value set on a non-reserved, non-number token");

endmodule

`default_nettype wire
